>>> src/lazy_segment_tree_range_add_sum_assert.svh
// Assertion macros for the range-add, range-sum store.
// Used by lazy_segment_tree_range_add_sum.sv; expects clock and reset in scope.
`ifndef LAZY_SEGMENT_TREE_RANGE_ADD_SUM_ASSERT_SVH
`define LAZY_SEGMENT_TREE_RANGE_ADD_SUM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSEG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSEG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/lseg_pkg.sv
// Shared constants for the range-add, range-sum store.
// No dependencies; imported by lazy_segment_tree_range_add_sum.
`timescale 1ns / 1ps

package lseg_pkg;

   localparam int DEF_MAX_ELEMENTS = 1024;
   localparam int DATA_W           = 64;
   localparam int DELTA_W          = 32;
   localparam int POS_W            = 10;
   localparam int SIZE_W           = 11;

   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_SUM = 1'b1;

endpackage

>>> src/lazy_segment_tree_range_add_sum.sv
// Range-add, range-sum store over signed 64-bit values, built around one memory.
// Depends on lseg_pkg.sv and lazy_segment_tree_range_add_sum_assert.svh.
//
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    func, left_index, right_index, delta
// rsp       out        rsp_valid/rsp_ready    range_sum (queries only)
// csr       in         csr_valid/csr_ready    num_elements
//
// The contents are kept as two Fenwick trees that share one memory word per index.
// An add does a read-modify-write of each memory word on its update path; a query reads
// each word on its prefix path, for both ends of the range, and does no writes.
// Reset and every csr transfer start a clearing pass over all MAX_ELEMENTS words.
// A finished query waits in the output register; a stalled rsp holds the next query.
`timescale 1ns / 1ps
`include "lazy_segment_tree_range_add_sum_assert.svh"

module lazy_segment_tree_range_add_sum #(
   parameter int MAX_ELEMENTS = lseg_pkg::DEF_MAX_ELEMENTS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [lseg_pkg::POS_W-1:0]            req_left_index,
   input  logic [lseg_pkg::POS_W-1:0]            req_right_index,
   input  logic signed [lseg_pkg::DELTA_W-1:0]   req_delta,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [lseg_pkg::DATA_W-1:0]    rsp_range_sum,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lseg_pkg::SIZE_W-1:0]           csr_num_elements
);
   import lseg_pkg::*;

   localparam int AW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int IW0 = $clog2(MAX_ELEMENTS) + 2;
   localparam int WW  = (IW0 > SIZE_W + 1) ? IW0 : SIZE_W + 1;
   localparam logic [WW-1:0] MAXW = WW'(MAX_ELEMENTS);
   localparam logic [WW-1:0] ONEW = WW'(1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_MULA, ST_MULB, ST_UPD_RD, ST_UPD_WR,
      ST_QRY_RD, ST_QRY_ACC, ST_QRY_MUL, ST_QRY_SUM, ST_DONE
   } state_type;

   state_type           state_ff;
   logic [AW-1:0]       clr_ff;
   logic [WW-1:0]       num_ff;
   logic [WW-1:0]       a_ff;
   logic [WW-1:0]       hi_ff;
   logic [WW-1:0]       idx_ff;
   logic [WW-1:0]       x_ff;
   logic                phase_ff;
   logic [DATA_W-1:0]   d_ff;
   logic [DATA_W-1:0]   dv_ff;
   logic [DATA_W-1:0]   w_ff;
   logic [DATA_W-1:0]   prod_ff;
   logic [DATA_W-1:0]   s1_ff;
   logic [DATA_W-1:0]   s2_ff;
   logic [DATA_W-1:0]   tot_ff;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_sum_ff;
   logic [2*DATA_W-1:0] rd_ff;

   logic [2*DATA_W-1:0] mem [MAX_ELEMENTS];

   logic [WW-1:0]       lowbit;
   logic [WW-1:0]       idx_up;
   logic [WW-1:0]       idx_dn;
   logic [WW-1:0]       last;
   logic [WW-1:0]       left_w;
   logic [WW-1:0]       right_w;
   logic [WW-1:0]       right_clip;
   logic [WW-1:0]       size_w;
   logic [WW-1:0]       size_in;
   logic [DATA_W-1:0]   mul_a;
   logic [WW-1:0]       mul_b;
   logic [DATA_W-1:0]   prod;
   logic [DATA_W-1:0]   rd_b1;
   logic [DATA_W-1:0]   rd_b2;
   logic [DATA_W-1:0]   part;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [2*DATA_W-1:0] wr_data;
   logic [AW-1:0]       rd_addr;
   logic                req_xfer;

   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;
   assign req_xfer      = req_valid && req_ready;

   assign lowbit     = idx_ff & (~idx_ff + ONEW);
   assign idx_up     = idx_ff + lowbit;
   assign idx_dn     = idx_ff - lowbit;
   assign last       = num_ff - ONEW;
   assign left_w     = WW'(req_left_index);
   assign right_w    = WW'(req_right_index);
   assign right_clip = (right_w > last) ? last : right_w;
   assign size_w     = WW'(csr_num_elements);
   assign size_in    = (size_w == '0) ? ONEW : ((size_w > MAXW) ? MAXW : size_w);
   assign rd_b1      = rd_ff[2*DATA_W-1:DATA_W];
   assign rd_b2      = rd_ff[DATA_W-1:0];
   assign part       = prod_ff - s2_ff;
   assign rd_addr    = AW'(idx_ff - ONEW);

   always_comb begin
      case (state_ff)
         ST_MULA: begin
            mul_a = d_ff;
            mul_b = a_ff;
         end
         ST_MULB: begin
            mul_a = d_ff;
            mul_b = hi_ff;
         end
         default: begin
            mul_a = s1_ff;
            mul_b = x_ff;
         end
      endcase
   end

   assign prod = mul_a * {{(DATA_W-WW){1'b0}}, mul_b};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_addr;
      wr_data = {rd_b1 + dv_ff, rd_b2 + w_ff};
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_UPD_WR: begin
            wr_en = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         num_ff       <= (MAXW < WW'(1024)) ? MAXW : WW'(1024);
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  a_ff     <= left_w;
                  hi_ff    <= right_clip + ONEW;
                  d_ff     <= DATA_W'(req_delta);
                  phase_ff <= 1'b0;
                  s1_ff    <= '0;
                  s2_ff    <= '0;
                  tot_ff   <= '0;
                  idx_ff   <= right_clip + ONEW;
                  x_ff     <= right_clip + ONEW;
                  if (left_w > right_clip) begin
                     state_ff <= (req_func == FUNC_SUM) ? ST_DONE : ST_IDLE;
                  end else begin
                     state_ff <= (req_func == FUNC_SUM) ? ST_QRY_RD : ST_MULA;
                  end
               end
            end
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(MAX_ELEMENTS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_MULA: begin
               w_ff     <= prod;
               dv_ff    <= d_ff;
               idx_ff   <= a_ff + ONEW;
               state_ff <= ST_MULB;
            end
            ST_MULB: begin
               prod_ff  <= prod;
               state_ff <= ST_UPD_RD;
            end
            ST_UPD_RD: begin
               state_ff <= ST_UPD_WR;
            end
            ST_UPD_WR: begin
               if (idx_up <= MAXW) begin
                  idx_ff   <= idx_up;
                  state_ff <= ST_UPD_RD;
               end else if (!phase_ff && (hi_ff + ONEW <= MAXW)) begin
                  phase_ff <= 1'b1;
                  idx_ff   <= hi_ff + ONEW;
                  dv_ff    <= '0 - d_ff;
                  w_ff     <= '0 - prod_ff;
                  state_ff <= ST_UPD_RD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_QRY_RD: begin
               state_ff <= ST_QRY_ACC;
            end
            ST_QRY_ACC: begin
               s1_ff    <= s1_ff + rd_b1;
               s2_ff    <= s2_ff + rd_b2;
               idx_ff   <= idx_dn;
               state_ff <= (idx_dn == '0) ? ST_QRY_MUL : ST_QRY_RD;
            end
            ST_QRY_MUL: begin
               prod_ff  <= prod;
               state_ff <= ST_QRY_SUM;
            end
            ST_QRY_SUM: begin
               if (!phase_ff) begin
                  tot_ff   <= part;
                  phase_ff <= 1'b1;
                  x_ff     <= a_ff;
                  idx_ff   <= a_ff;
                  s1_ff    <= '0;
                  s2_ff    <= '0;
                  state_ff <= (a_ff == '0) ? ST_QRY_MUL : ST_QRY_RD;
               end else begin
                  tot_ff   <= tot_ff - part;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_sum_ff   <= tot_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (csr_valid && csr_ready) begin
            num_ff   <= size_in;
            clr_ff   <= '0;
            state_ff <= ST_CLEAR;
         end
      end
   end

   `LSEG_ASSERT_NOW(a_clear_blocks_req, state_ff == ST_CLEAR, !req_ready, "req taken during clear")
   `LSEG_ASSERT_NEXT(a_csr_starts_clear, csr_valid && csr_ready, state_ff == ST_CLEAR, "no clear after csr")
   `LSEG_ASSERT_NEXT(a_req_busy, req_xfer && !csr_valid, !req_ready || state_ff == ST_IDLE, "busy flag lost")
   `LSEG_ASSERT_NOW(a_upd_index, state_ff == ST_UPD_RD, idx_ff != '0 && idx_ff <= MAXW, "bad tree index")

endmodule

>>> bench/lazy_segment_tree_range_add_sum_tb.sv
// Self-checking bench for the range-add, range-sum store: directed and random adds
// and queries under several sizes, with a scoreboard that keeps a flat array of values.
// Depends on lseg_pkg.sv and lazy_segment_tree_range_add_sum.sv.
`timescale 1ns / 1ps

module lazy_segment_tree_range_add_sum_tb;
   import lseg_pkg::*;

   class range_sum_board;
      longint values [DEF_MAX_ELEMENTS];
      int     size;
      longint pending_sums [$];
      int     errors;

      function void resize(int v);
         size = (v < 1) ? 1 : (v > DEF_MAX_ELEMENTS) ? DEF_MAX_ELEMENTS : v;
         foreach (values[i]) values[i] = 0;
      endfunction

      function void note_request(logic f, int lo, int hi, logic signed [DELTA_W-1:0] d);
         longint acc;
         int top;
         acc = 0;
         top = (hi < size) ? hi : size - 1;
         for (int i = lo; i <= top; i++) begin
            if (f == FUNC_ADD) values[i] += longint'(d);
            else acc += values[i];
         end
         if (f == FUNC_SUM) pending_sums = {pending_sums, acc};
      endfunction

      function void check_sum(longint got);
         longint want;
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d", $time, got);
            errors++;
         end else begin
            want = pending_sums.pop_front();
            if (want != got) begin
               $display("%0t: range_sum mismatch, expected %0d, actual %0d", $time, want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, req_func;
   logic [POS_W-1:0] req_left_index, req_right_index;
   logic signed [DELTA_W-1:0] req_delta;
   logic rsp_valid, rsp_ready;
   logic signed [DATA_W-1:0] rsp_range_sum;
   logic csr_valid, csr_ready;
   logic [SIZE_W-1:0] csr_num_elements;

   range_sum_board board;
   bit quiet;

   lazy_segment_tree_range_add_sum uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_left_index(req_left_index), .req_right_index(req_right_index),
      .req_delta(req_delta),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_range_sum(rsp_range_sum),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_num_elements(csr_num_elements)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("lazy_segment_tree_range_add_sum_tb NOT OK");
      $finish;
   end

   task automatic send(logic f, int lo, int hi, logic signed [DELTA_W-1:0] d);
      req_valid <= 1;
      req_func <= f;
      req_left_index <= lo[POS_W-1:0];
      req_right_index <= hi[POS_W-1:0];
      req_delta <= d;
      do @(posedge clock); while (!req_ready);
      board.note_request(f, lo, hi, d);
      if (!quiet && $urandom_range(3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic write_size(int v);
      req_valid <= 0;
      @(posedge clock);
      while (board.pending_sums.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_valid <= 1;
      csr_num_elements <= v[SIZE_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      board.resize(v);
   endtask

   function automatic logic signed [DELTA_W-1:0] rand_delta();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(200)) - 100;
      endcase
   endfunction

   task automatic random_items(int count);
      int lo, hi, span;
      for (int i = 0; i < count; i++) begin
         span = (board.size >= 1000 || $urandom_range(7) == 0) ? 1023
              : board.size + board.size / 4 + 2;
         lo = $urandom_range(span);
         hi = ($urandom_range(9) == 0) ? $urandom_range(span) : $urandom_range(span, lo);
         send($urandom_range(1) ? FUNC_SUM : FUNC_ADD, lo, hi, rand_delta());
      end
   endtask

   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) board.check_sum(rsp_range_sum);
         if (idle > 0) idle--;
         else if (!quiet && $urandom_range(4) == 0) idle = $urandom_range(1, 4);
         rsp_ready <= (idle == 0);
      end
   end

   initial begin
      int sizes [7];
      sizes = '{0, 2047, 5, 37, 1000, 1, 1024};
      board = new();
      board.resize(DEF_MAX_ELEMENTS);
      reset <= 1;
      req_valid <= 0; req_func <= FUNC_ADD; req_left_index <= 0; req_right_index <= 0;
      req_delta <= 0; rsp_ready <= 0; csr_valid <= 0; csr_num_elements <= 0;
      repeat (11) @(posedge clock);
      reset <= 0;

      send(FUNC_ADD, 0, 1023, 32'sh7fffffff);
      send(FUNC_SUM, 0, 1023, 0);
      send(FUNC_ADD, 1023, 1023, 32'sh80000000);
      send(FUNC_ADD, 0, 0, -1);
      send(FUNC_SUM, 1023, 1023, 0);
      send(FUNC_SUM, 0, 0, 0);
      send(FUNC_ADD, 700, 300, 12345);
      send(FUNC_SUM, 700, 300, 0);
      send(FUNC_ADD, 341, 682, -77);
      send(FUNC_SUM, 340, 683, 0);
      send(FUNC_SUM, 512, 512, 0);
      send(FUNC_SUM, 0, 1023, 0);
      write_size(10);
      send(FUNC_ADD, 5, 1023, 9);
      send(FUNC_ADD, 10, 1023, 1000);
      send(FUNC_SUM, 0, 1023, 0);
      send(FUNC_SUM, 9, 9, 0);
      send(FUNC_SUM, 10, 20, 0);
      send(FUNC_SUM, 3, 1, 0);

      foreach (sizes[p]) begin
         write_size(sizes[p]);
         if (p == 6) quiet = 1;
         random_items(150);
      end

      req_valid <= 0;
      while (board.pending_sums.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0) $display("lazy_segment_tree_range_add_sum_tb OK");
      else $display("lazy_segment_tree_range_add_sum_tb NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/lseg_pkg.sv
src/lazy_segment_tree_range_add_sum.sv
bench/lazy_segment_tree_range_add_sum_tb.sv
